@@ rtl/xor_checked_frame_deframer_unit_defines.svh @@
// ----------------------------------------------------------------------------
// xor_checked_frame_deframer_unit_defines.svh
// Assertion macros shared by the deframer modules.
// ----------------------------------------------------------------------------
`ifndef XOR_CHECKED_FRAME_DEFRAMER_UNIT_DEFINES_SVH
`define XOR_CHECKED_FRAME_DEFRAMER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define XCFD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define XCFD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/xcfd_pkg.sv @@
// ----------------------------------------------------------------------------
// xcfd_pkg
// Types and constants of the xor-checked frame deframer.
// ----------------------------------------------------------------------------
package xcfd_pkg;

	// frame start marker
	localparam logic [7:0] MARKER_BYTE = 8'hFF;
	// header bytes including the marker
	localparam int unsigned HEADER_LEN = 6;

	// header position: next byte to take
	typedef enum logic [2:0] {
		POS_IDLE    = 3'd0,
		POS_LEN_LO  = 3'd1,
		POS_LEN_HI  = 3'd2,
		POS_CMD     = 3'd3,
		POS_COUNT   = 3'd4,
		POS_CHECK   = 3'd5,
		POS_PAYLOAD = 3'd6
	} hdr_pos_t;

	// one result item
	typedef struct packed {
		logic [7:0] payload_byte;
		logic [7:0] frame_command;
		logic       byte_valid;
		logic       frame_end;
		logic       check_ok;
		logic       start_dropped;
	} result_t;

endpackage

@@ rtl/xor_checked_frame_deframer_unit.sv @@
// ----------------------------------------------------------------------------
// xor_checked_frame_deframer_unit
// Byte-wise deframer for length-prefixed frames with an XOR check byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one received byte per item, with
//   fragment_last marking the last byte of a link fragment.
//   Output channel (out_valid / out_stall): zero or one result item per
//   input item: a payload byte with its frame command, a frame end flag
//   with the XOR check result, or a dropped-start-byte flag. Header bytes
//   and frame tail bytes give none, save an empty frame's check byte.
//   Path: an accepted byte lands in the input register, then its decode
//   is loaded into the result register, from which the receiver takes
//   it while out_stall is low.
//   Throughput: one byte per cycle while the receiver takes results; the
//   frame state update is a single pass of small logic per byte.
//   Stall: while out_stall holds a waiting result, the byte in the input
//   register waits and in_stall rises once that register is occupied.
//   Reset: arst_n clears the valid flags of both registers and the frame
//   state; the block starts idle, waiting for a 0xFF marker.
// ----------------------------------------------------------------------------
module xor_checked_frame_deframer_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	input  logic       fragment_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] payload_byte,
	output logic [7:0] frame_command,
	output logic       byte_valid,
	output logic       frame_end,
	output logic       check_ok,
	output logic       start_dropped
);
	import xcfd_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       blocked;
	logic       go;
	logic       accept;
	logic       res_valid;
	result_t    res;
	result_t    out_res;

	// handshake
	assign go       = valid_s1 && !blocked;
	assign in_stall = valid_s1 && blocked;
	assign accept   = in_valid && !in_stall;

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= rx_byte;
			last_s1 <= fragment_last;
		end
	end

	// frame decode
	xcfd_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.go            (go),
		.rx_byte       (byte_s1),
		.fragment_last (last_s1),
		.res           (res),
		.res_valid     (res_valid)
	);

	// result register
	xcfd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (go && res_valid),
		.res       (res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.blocked   (blocked),
		.out_res   (out_res)
	);

	assign payload_byte  = out_res.payload_byte;
	assign frame_command = out_res.frame_command;
	assign byte_valid    = out_res.byte_valid;
	assign frame_end     = out_res.frame_end;
	assign check_ok      = out_res.check_ok;
	assign start_dropped = out_res.start_dropped;

endmodule

@@ rtl/xcfd_parser.sv @@
// ----------------------------------------------------------------------------
// xcfd_parser
// Frame state and combinational decode of one received byte.
// ----------------------------------------------------------------------------
`include "xor_checked_frame_deframer_unit_defines.svh"

module xcfd_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic [7:0]        rx_byte,
	input  logic              fragment_last,
	output xcfd_pkg::result_t res,
	output logic              res_valid
);
	import xcfd_pkg::*;

	hdr_pos_t    pos_q, pos_d;
	logic [15:0] remain_q, remain_d, remain_dec;
	logic [7:0]  cmd_q, cmd_d;
	logic [7:0]  exp_q, exp_d;
	logic [7:0]  run_q, run_d, run_xor;
	logic        discard_q, discard_d;

	// frame state registers, advanced once per processed item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= POS_IDLE;
			remain_q  <= '0;
			cmd_q     <= '0;
			exp_q     <= '0;
			run_q     <= '0;
			discard_q <= 1'b0;
		end else if (go) begin
			pos_q     <= pos_d;
			remain_q  <= remain_d;
			cmd_q     <= cmd_d;
			exp_q     <= exp_d;
			run_q     <= run_d;
			discard_q <= discard_d;
		end
	end

	assign run_xor    = run_q ^ rx_byte;
	assign remain_dec = remain_q - 16'd1;

	// next state and result
	always_comb begin
		pos_d     = pos_q;
		remain_d  = remain_q;
		cmd_d     = cmd_q;
		exp_d     = exp_q;
		run_d     = run_q;
		discard_d = discard_q;
		res       = '0;
		res_valid = 1'b0;
		if (discard_q) begin
			// drop trailing bytes up to the fragment end
			if (fragment_last) begin
				discard_d = 1'b0;
			end
		end else begin
			case (pos_q)
				POS_LEN_LO: begin
					remain_d = {remain_q[15:8], rx_byte};
					pos_d    = POS_LEN_HI;
				end
				POS_LEN_HI: begin
					remain_d = {rx_byte, remain_q[7:0]};
					pos_d    = POS_CMD;
				end
				POS_CMD: begin
					cmd_d = rx_byte;
					pos_d = POS_COUNT;
				end
				POS_COUNT: begin
					// packet count is ignored
					pos_d = POS_CHECK;
				end
				POS_CHECK: begin
					exp_d = rx_byte;
					run_d = '0;
					if (remain_q == 16'd0) begin
						// empty frame ends on the check byte
						res.frame_command = cmd_q;
						res.frame_end     = 1'b1;
						res.check_ok      = (rx_byte == 8'd0);
						res_valid         = 1'b1;
						pos_d             = POS_IDLE;
						remain_d          = '0;
						discard_d         = !fragment_last;
					end else begin
						pos_d = POS_PAYLOAD;
					end
				end
				POS_PAYLOAD: begin
					run_d              = run_xor;
					remain_d           = remain_dec;
					res.payload_byte   = rx_byte;
					res.frame_command  = cmd_q;
					res.byte_valid     = 1'b1;
					res_valid          = 1'b1;
					if (remain_dec == 16'd0) begin
						res.frame_end = 1'b1;
						res.check_ok  = (run_xor == exp_q);
						pos_d         = POS_IDLE;
						remain_d      = '0;
						discard_d     = !fragment_last;
					end
				end
				default: begin
					// idle: wait for the marker
					if (rx_byte != MARKER_BYTE) begin
						res.start_dropped = 1'b1;
						res_valid         = 1'b1;
						pos_d             = POS_IDLE;
					end else begin
						pos_d    = POS_LEN_LO;
						remain_d = '0;
						run_d    = '0;
					end
				end
			endcase
		end
	end

	// assertions
	`XCFD_ASSERT_SAME(a_drop_alone, go && res_valid && res.start_dropped,
		!res.byte_valid && !res.frame_end, "dropped start byte carries payload flags")
	`XCFD_ASSERT_NEXT(a_end_idle, go && res_valid && res.frame_end,
		pos_q == POS_IDLE, "frame end did not return to idle")
	`XCFD_ASSERT_SAME(a_discard_quiet, go && discard_q,
		!res_valid, "result produced while dropping trailing bytes")

endmodule

@@ rtl/xcfd_out_stage.sv @@
// ----------------------------------------------------------------------------
// xcfd_out_stage
// Result register toward the receiver, held while the receiver stalls.
// ----------------------------------------------------------------------------
module xcfd_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  xcfd_pkg::result_t res,
	input  logic              out_stall,
	output logic              out_valid,
	output logic              blocked,
	output xcfd_pkg::result_t out_res
);
	import xcfd_pkg::*;

	logic    valid_q;
	result_t res_q;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign blocked   = valid_q && out_stall;
	assign out_valid = valid_q;
	assign out_res   = res_q;

endmodule

@@ test/xcfd_deframe_checker.sv @@
// ----------------------------------------------------------------------------
// xcfd_deframe_checker
// Watches both channels of the deframer, tracks the frame state on its own
// and checks every result item against the one due for the accepted bytes.
// ----------------------------------------------------------------------------
module xcfd_deframe_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] rx_byte,
	input  logic       fragment_last,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [7:0] payload_byte,
	input  logic [7:0] frame_command,
	input  logic       byte_valid,
	input  logic       frame_end,
	input  logic       check_ok,
	input  logic       start_dropped,
	output int         fail_count,
	output int         results_due,
	output int         frames_closed,
	output int         bad_checks,
	output int         start_drops,
	output int         payload_seen
);
	import xcfd_pkg::*;

	// frame state of the deframer as this side sees it
	hdr_pos_t    pos;
	logic [15:0] remaining;
	logic [7:0]  cmd;
	logic [7:0]  want_check;
	logic [7:0]  run_check;
	logic        discard;

	// results owed by bytes already taken, oldest first
	result_t     deframed_due[$];
	result_t     due;
	int          result_index;

	task automatic report_mismatch(input string what, input logic [7:0] got,
		input logic [7:0] want);
		$display("%0t: result %0d: %s: got %02h, want %02h", $time, result_index,
			what, got, want);
		fail_count++;
	endtask

	// advance the frame state by one byte and queue the result it causes
	task automatic predict_deframe(input logic [7:0] b, input logic last);
		result_t r;
		r = '0;
		if (discard) begin
			// rest of a fragment after a finished frame
			if (last)
				discard = 1'b0;
		end else begin
			case (pos)
				POS_LEN_LO: begin
					remaining[7:0] = b;
					pos = POS_LEN_HI;
				end
				POS_LEN_HI: begin
					remaining[15:8] = b;
					pos = POS_CMD;
				end
				POS_CMD: begin
					cmd = b;
					pos = POS_COUNT;
				end
				POS_COUNT: pos = POS_CHECK;
				POS_CHECK: begin
					want_check = b;
					run_check = '0;
					if (remaining == 16'd0) begin
						// empty frame ends on its check byte
						r.frame_command = cmd;
						r.frame_end = 1'b1;
						r.check_ok = (b == 8'h00);
						pos = POS_IDLE;
						discard = !last;
						deframed_due.push_back(r);
						frames_closed++;
						if (!r.check_ok)
							bad_checks++;
					end else begin
						pos = POS_PAYLOAD;
					end
				end
				POS_PAYLOAD: begin
					run_check = run_check ^ b;
					remaining = remaining - 16'd1;
					r.payload_byte = b;
					r.frame_command = cmd;
					r.byte_valid = 1'b1;
					payload_seen++;
					if (remaining == 16'd0) begin
						r.frame_end = 1'b1;
						r.check_ok = (run_check == want_check);
						pos = POS_IDLE;
						discard = !last;
						frames_closed++;
						if (!r.check_ok)
							bad_checks++;
					end
					deframed_due.push_back(r);
				end
				default: begin
					if (b != MARKER_BYTE) begin
						pos = POS_IDLE;
						r.start_dropped = 1'b1;
						deframed_due.push_back(r);
						start_drops++;
					end else begin
						pos = POS_LEN_LO;
						remaining = '0;
						run_check = '0;
					end
				end
			endcase
		end
	endtask

	// compare taken results first, then predict from the taken byte
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos = POS_IDLE;
			remaining = '0;
			cmd = '0;
			want_check = '0;
			run_check = '0;
			discard = 1'b0;
			deframed_due.delete();
			fail_count = 0;
			results_due = 0;
			frames_closed = 0;
			bad_checks = 0;
			start_drops = 0;
			payload_seen = 0;
			result_index = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (deframed_due.size() == 0) begin
					report_mismatch("result with nothing due", payload_byte, 8'h00);
				end else begin
					due = deframed_due.pop_front();
					if (payload_byte !== due.payload_byte)
						report_mismatch("payload_byte", payload_byte, due.payload_byte);
					if (frame_command !== due.frame_command)
						report_mismatch("frame_command", frame_command, due.frame_command);
					if (byte_valid !== due.byte_valid)
						report_mismatch("byte_valid", 8'(byte_valid), 8'(due.byte_valid));
					if (frame_end !== due.frame_end)
						report_mismatch("frame_end", 8'(frame_end), 8'(due.frame_end));
					if (check_ok !== due.check_ok)
						report_mismatch("check_ok", 8'(check_ok), 8'(due.check_ok));
					if (start_dropped !== due.start_dropped)
						report_mismatch("start_dropped", 8'(start_dropped),
							8'(due.start_dropped));
				end
				result_index++;
			end
			if (in_valid && !in_stall)
				predict_deframe(rx_byte, fragment_last);
			results_due = deframed_due.size();
		end
	end

endmodule

@@ test/tb_xor_checked_frame_deframer_unit.sv @@
// ----------------------------------------------------------------------------
// tb_xor_checked_frame_deframer_unit
// Drives byte streams into the deframer: a few hand-picked frames and bad
// start bytes, then random frames of mostly small lengths with good and bad
// check bytes, fragment edges, dropped tails and idle noise, with random
// gaps on both channels. A checker beside the block judges every result.
// ----------------------------------------------------------------------------
module tb_xor_checked_frame_deframer_unit;
	import xcfd_pkg::*;

	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int STREAM_BYTES = 1880;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] rx_byte = 8'h00;
	logic       fragment_last = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] payload_byte;
	logic [7:0] frame_command;
	logic       byte_valid;
	logic       frame_end;
	logic       check_ok;
	logic       start_dropped;

	int fail_count;
	int results_due;
	int frames_closed;
	int bad_checks;
	int start_drops;
	int payload_seen;

	int cycle_count = 0;
	int stall_hold = 0;
	bit out_calm = 1'b0;
	bit in_calm = 1'b0;
	int bytes_sent = 0;
	int bytes_dropped = 0;

	xor_checked_frame_deframer_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.fragment_last(fragment_last),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.payload_byte (payload_byte),
		.frame_command(frame_command),
		.byte_valid   (byte_valid),
		.frame_end    (frame_end),
		.check_ok     (check_ok),
		.start_dropped(start_dropped)
	);

	xcfd_deframe_checker deframe_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.fragment_last(fragment_last),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.payload_byte (payload_byte),
		.frame_command(frame_command),
		.byte_valid   (byte_valid),
		.frame_end    (frame_end),
		.check_ok     (check_ok),
		.start_dropped(start_dropped),
		.fail_count   (fail_count),
		.results_due  (results_due),
		.frames_closed(frames_closed),
		.bad_checks   (bad_checks),
		.start_drops  (start_drops),
		.payload_seen (payload_seen)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_xor_checked_frame_deframer_unit: done, errors");
			$finish;
		end
	end

	// gap length: mostly none or short, a few long
	function automatic int pick_gap(input bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// payload length: mostly short, rarely past one length byte
	function automatic logic [15:0] pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return 16'($urandom_range(1, 8));
		if (r < 99)
			return 16'($urandom_range(9, 40));
		return 16'($urandom_range(256, 400));
	endfunction

	// fragment edge inside a frame, which the block ignores
	function automatic logic mid_last();
		return $urandom_range(0, 9) == 0;
	endfunction

	// receiver stalls
	always @(negedge clk) begin
		if (stall_hold > 0) begin
			out_stall <= 1'b1;
			stall_hold <= stall_hold - 1;
		end else begin
			out_stall <= 1'b0;
			stall_hold <= pick_gap(out_calm);
		end
		if ($urandom_range(0, 399) == 0)
			out_calm <= !out_calm;
	end

	// hand one byte over; entered and left at a falling edge
	task automatic put_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = pick_gap(in_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		fragment_last <= last;
		do @(posedge clk); while (in_stall);
		bytes_sent++;
		@(negedge clk);
	endtask

	// hold the sender until every due result has come
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(negedge clk); while (results_due != 0);
	endtask

	// one frame; a frame ending mid-fragment is followed by its dropped tail
	task automatic send_frame(input logic [15:0] len, input bit bad_check,
		input bit end_last);
		logic [7:0] body[$];
		logic [7:0] xsum;
		logic [7:0] b;
		logic [7:0] chk;
		int         k;
		int         tail;
		body.delete();
		xsum = 8'h00;
		for (k = 0; k < int'(len); k++) begin
			b = ($urandom_range(0, 7) == 0) ? MARKER_BYTE : 8'($urandom);
			body.push_back(b);
			xsum = xsum ^ b;
		end
		chk = bad_check ? (xsum ^ 8'($urandom_range(1, 255))) : xsum;
		put_byte(MARKER_BYTE, mid_last());
		put_byte(len[7:0], mid_last());
		put_byte(len[15:8], mid_last());
		put_byte(8'($urandom), mid_last());
		put_byte(8'($urandom), mid_last());
		put_byte(chk, (len == 16'd0) ? end_last : mid_last());
		for (k = 0; k < int'(len); k++)
			put_byte(body[k], (k == int'(len) - 1) ? end_last : mid_last());
		if (!end_last) begin
			tail = $urandom_range(0, 5);
			repeat (tail) put_byte(8'($urandom), 1'b0);
			put_byte(8'($urandom), 1'b1);
			bytes_dropped += tail + 1;
		end
	endtask

	// stimulus
	initial begin
		int n;
		int spins;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// bad start bytes at both ends of the range
		put_byte(8'h00, 1'b0);
		put_byte(8'hFE, 1'b1);
		// empty frame, zero check byte, ends its fragment
		put_byte(MARKER_BYTE, 1'b0);
		put_byte(8'h00, 1'b0);
		put_byte(8'h00, 1'b1);
		put_byte(8'hFF, 1'b0);
		put_byte(8'hFF, 1'b0);
		put_byte(8'h00, 1'b1);
		// empty frame with nonzero check, ends mid-fragment, marker in the tail
		put_byte(MARKER_BYTE, 1'b1);
		put_byte(8'h00, 1'b0);
		put_byte(8'h00, 1'b0);
		put_byte(8'h00, 1'b0);
		put_byte(8'h00, 1'b0);
		put_byte(8'h5A, 1'b0);
		put_byte(MARKER_BYTE, 1'b0);
		put_byte(8'h00, 1'b1);
		bytes_dropped += 2;
		// one all-ones payload byte with a matching check
		put_byte(MARKER_BYTE, 1'b0);
		put_byte(8'h01, 1'b0);
		put_byte(8'h00, 1'b0);
		put_byte(8'h7E, 1'b0);
		put_byte(8'h01, 1'b0);
		put_byte(8'hFF, 1'b0);
		put_byte(8'hFF, 1'b1);
		drain_results();

		// random frames, noise and pauses
		while (bytes_sent < STREAM_BYTES) begin
			if ($urandom_range(0, 19) == 0)
				in_calm = !in_calm;
			n = $urandom_range(0, 99);
			if (n < 70) begin
				send_frame(pick_len(), $urandom_range(0, 3) == 0,
					1'($urandom_range(0, 1)));
			end else if (n < 88) begin
				// idle bytes that are not the marker
				repeat ($urandom_range(1, 4))
					put_byte(8'($urandom_range(0, 254)), 1'($urandom_range(0, 1)));
			end else if (n < 97) begin
				send_frame(16'd0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end else begin
				drain_results();
			end
		end
		in_valid <= 1'b0;

		// wait out the results still owed
		spins = 0;
		while (results_due != 0 && spins < 10000) begin
			@(negedge clk);
			spins++;
		end
		repeat (8) @(negedge clk);

		$display("covered %0d bytes in (%0d dropped as frame tails), %0d payload bytes out",
			bytes_sent, bytes_dropped, payload_seen);
		$display("%0d frames closed, %0d with a check mismatch, %0d bad start bytes",
			frames_closed, bad_checks, start_drops);
		if (results_due != 0)
			$display("%0d results never arrived", results_due);
		if (fail_count == 0 && results_due == 0)
			$display("tb_xor_checked_frame_deframer_unit: done, clean");
		else
			$display("tb_xor_checked_frame_deframer_unit: done, errors");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/xcfd_pkg.sv
rtl/xcfd_parser.sv
rtl/xcfd_out_stage.sv
rtl/xor_checked_frame_deframer_unit.sv
test/xcfd_deframe_checker.sv
test/tb_xor_checked_frame_deframer_unit.sv
